>>> rtl/core/spch_pkg.sv
// ----------------------------------------------------------------------------
// spch_pkg
// Shared constants and types for the convex hull engine: store sizing,
// coordinate width, vertex type, turn unit result and result status codes.
// ----------------------------------------------------------------------------
package spch_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int COORD_BITS  = 16;

    localparam int PTR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int CAP_W  = 6;
    localparam int LEN_W  = 6;
    localparam int STAT_W = 2;

    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * COORD_BITS + LEN_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        logic done;
        logic neg;
    } t_turn_res;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK  = 2'd0,
        STAT_FEW = 2'd1,
        STAT_CAP = 2'd2,
        STAT_OVF = 2'd3
    } t_status;

endpackage

>>> rtl/core/spch_turn.sv
// ----------------------------------------------------------------------------
// spch_turn
// Iterative turn test: sign of (b-a) x (c-a) with one shared multiplier,
// two products computed in turn, then a registered compare.
// ----------------------------------------------------------------------------
module spch_turn (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  spch_pkg::t_point   i_a,
    input  spch_pkg::t_point   i_b,
    input  spch_pkg::t_point   i_c,
    output spch_pkg::t_turn_res o_res
);

    localparam int DW = spch_pkg::COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_P,
        TS_Q,
        TS_CMP
    } t_tstate;

    t_tstate                r_state;
    logic signed [PW-1:0]   r_p;
    logic signed [PW-1:0]   r_q;
    logic                   r_done;
    logic                   r_neg;

    logic signed [DW-1:0]   w_m0;
    logic signed [DW-1:0]   w_m1;
    logic signed [PW-1:0]   w_prod;
    logic signed [PW:0]     w_diff;

    always_comb begin
        if (r_state == TS_P) begin
            w_m0 = DW'(i_b.x) - DW'(i_a.x);
            w_m1 = DW'(i_c.y) - DW'(i_a.y);
        end else begin
            w_m0 = DW'(i_c.x) - DW'(i_a.x);
            w_m1 = DW'(i_b.y) - DW'(i_a.y);
        end
        w_prod = PW'(w_m0) * PW'(w_m1);
        w_diff = (PW+1)'(r_p) - (PW+1)'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_done  <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_done <= (r_state == TS_CMP);
            case (r_state)
                TS_IDLE: begin
                    if (i_start) r_state <= TS_P;
                end
                TS_P: begin
                    r_p     <= w_prod;
                    r_state <= TS_Q;
                end
                TS_Q: begin
                    r_q     <= w_prod;
                    r_state <= TS_CMP;
                end
                TS_CMP: begin
                    r_neg   <= w_diff[PW];
                    r_state <= TS_IDLE;
                end
                default: r_state <= TS_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;

endmodule

>>> rtl/core/simple_polygon_convex_hull_top.sv
// ----------------------------------------------------------------------------
// simple_polygon_convex_hull_top
// Online convex hull of a simple polygon with a circular double-ended store.
// Seed vertices are stored; the third vertex orients the seed with one turn test.
// A later vertex takes two turn tests inside the hull, plus a test per popped
// entry outside it (a turn test is two reads on the single store read port and
// a wait for the turn unit). A final vertex adds the hull output, held by output
// stalls; the block is not ready meanwhile. Reset clears run state and sets
// capacity to 63; the store itself is not cleared.
// ----------------------------------------------------------------------------
module simple_polygon_convex_hull_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spch_pkg::IN_W-1:0]     s_axis_tdata,   // point_x, point_y
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spch_pkg::OUT_W-1:0]    m_axis_tdata,   // hull_x, hull_y, hull_length
    output logic                          m_axis_tlast,
    output logic [spch_pkg::STAT_W-1:0]   m_axis_tuser,   // status
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spch_pkg::CAP_W-1:0]    i_cfg_data
);

    localparam int PTR_W = spch_pkg::PTR_W;
    localparam int CNT_W = spch_pkg::CNT_W;
    localparam int CB    = spch_pkg::COORD_BITS;
    localparam int PAD_W = spch_pkg::OUT_W - 2 * CB - spch_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_TURN,
        ST_SEED_WR,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_TURN,
        ST_PUSH_F,
        ST_PUSH_B,
        ST_ITEM_END,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef enum logic [1:0] {
        PH_TEST_F,
        PH_TEST_B,
        PH_POP_F,
        PH_POP_B
    } t_phase;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(spch_pkg::STORE_DEPTH))
            sum = sum - (CNT_W+1)'(spch_pkg::STORE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    t_state                  r_state;
    t_phase                  r_phase;
    logic [1:0]              r_ps;
    logic [PTR_W-1:0]        r_fp;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_ovf;
    logic                    r_few;
    logic                    r_flag;
    logic                    r_last;
    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_len;
    logic                    r_turn_start;
    logic [spch_pkg::CAP_W-1:0] r_cap;
    spch_pkg::t_point        r_s0;
    spch_pkg::t_point        r_s1;
    spch_pkg::t_point        r_cur;
    spch_pkg::t_point        r_pa;
    spch_pkg::t_point        r_pb;

    logic                    r_out_valid;
    logic                    r_out_last;
    spch_pkg::t_point        r_out_pt;
    logic [spch_pkg::LEN_W-1:0] r_out_len;
    spch_pkg::t_status       r_out_status;

    spch_pkg::t_point        r_mem [spch_pkg::STORE_DEPTH];
    spch_pkg::t_point        r_rd_data;

    spch_pkg::t_point        w_in_pt;
    spch_pkg::t_turn_res     w_turn;
    logic                    w_front;
    logic                    w_full;
    logic                    w_out_free;
    logic                    w_out_load;
    logic                    w_turn_go;
    logic [PTR_W-1:0]        w_fp_dec;
    logic [PTR_W-1:0]        w_raddr;
    logic                    w_we;
    logic [PTR_W-1:0]        w_waddr;
    spch_pkg::t_point        w_wdata;
    logic [CNT_W-1:0]        w_len;
    spch_pkg::t_status       w_err;

    assign w_in_pt.x   = s_axis_tdata[CB-1:0];
    assign w_in_pt.y   = s_axis_tdata[2*CB-1:CB];
    assign w_front     = (r_phase == PH_TEST_F) || (r_phase == PH_POP_F);
    assign w_full      = (r_cnt >= CNT_W'(spch_pkg::STORE_DEPTH));
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_fp_dec    = (r_fp == '0) ? PTR_W'(spch_pkg::STORE_DEPTH - 1) : r_fp - 1'b1;
    assign w_len       = r_cnt - 1'b1;
    assign w_out_load  = w_out_free &&
                         ((r_state == ST_FINISH && w_err != spch_pkg::STAT_OK) ||
                          (r_state == ST_EMIT_LD));
    assign w_turn_go   = (r_state == ST_IDLE && s_axis_tvalid && r_ps == 2'd2) ||
                         (r_state == ST_RD_C);

    always_comb begin
        if (r_few)
            w_err = spch_pkg::STAT_FEW;
        else if (r_ovf)
            w_err = spch_pkg::STAT_OVF;
        else if (int'(w_len) > int'(r_cap))
            w_err = spch_pkg::STAT_CAP;
        else
            w_err = spch_pkg::STAT_OK;
    end

    always_comb begin
        case (r_state)
            ST_RD_A:    w_raddr = w_front ? r_fp : slot_of(r_fp, r_cnt - CNT_W'(2));
            ST_RD_B:    w_raddr = w_front ? slot_of(r_fp, CNT_W'(1))
                                          : slot_of(r_fp, r_cnt - CNT_W'(1));
            ST_EMIT_RD: w_raddr = slot_of(r_fp, r_k);
            ST_EMIT_LD: w_raddr = slot_of(r_fp, r_k);
            default:    w_raddr = '0;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_cur;
        case (r_state)
            ST_SEED_WR: begin
                w_we = 1'b1;
                if (r_k == CNT_W'(3))
                    w_waddr = PTR_W'(spch_pkg::STORE_DEPTH - 1);
                else
                    w_waddr = PTR_W'(r_k);
                if (r_k == '0)
                    w_wdata = r_flag ? r_s0 : r_s1;
                else if (r_k == CNT_W'(1))
                    w_wdata = r_flag ? r_s1 : r_s0;
            end
            ST_PUSH_F: begin
                w_we    = !w_full;
                w_waddr = w_fp_dec;
            end
            ST_PUSH_B: begin
                w_we    = !w_full;
                w_waddr = slot_of(r_fp, r_cnt);
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd_data <= r_mem[w_raddr];
    end

    spch_turn u_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_turn_start),
        .i_a     (r_pa),
        .i_b     (r_pb),
        .i_c     (r_cur),
        .o_res   (w_turn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_TEST_F;
            r_ps         <= '0;
            r_fp         <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_few        <= 1'b0;
            r_turn_start <= 1'b0;
            r_cap        <= spch_pkg::CAP_W'(63);
            r_out_valid  <= 1'b0;
        end else begin
            r_turn_start <= w_turn_go;
            if (i_cfg_valid) r_cap <= i_cfg_data;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cur  <= w_in_pt;
                        r_last <= s_axis_tlast;
                        case (r_ps)
                            2'd0, 2'd1: begin
                                if (r_ps == 2'd0) r_s0 <= w_in_pt;
                                else r_s1 <= w_in_pt;
                                if (s_axis_tlast) begin
                                    r_few   <= 1'b1;
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_ps <= r_ps + 1'b1;
                                end
                            end
                            2'd2: begin
                                r_pa    <= r_s0;
                                r_pb    <= r_s1;
                                r_state <= ST_SEED_TURN;
                            end
                            default: begin
                                r_phase <= PH_TEST_F;
                                r_state <= ST_RD_A;
                            end
                        endcase
                    end
                end
                ST_SEED_TURN: begin
                    if (w_turn.done) begin
                        r_flag  <= w_turn.neg;
                        r_k     <= '0;
                        r_state <= ST_SEED_WR;
                    end
                end
                ST_SEED_WR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == CNT_W'(3)) begin
                        r_fp    <= PTR_W'(spch_pkg::STORE_DEPTH - 1);
                        r_cnt   <= CNT_W'(4);
                        r_ps    <= 2'd3;
                        r_state <= ST_ITEM_END;
                    end
                end
                ST_RD_A: r_state <= ST_RD_B;
                ST_RD_B: begin
                    r_pa    <= r_rd_data;
                    r_state <= ST_RD_C;
                end
                ST_RD_C: begin
                    r_pb    <= r_rd_data;
                    r_state <= ST_TURN;
                end
                ST_TURN: begin
                    if (w_turn.done) begin
                        case (r_phase)
                            PH_TEST_F: begin
                                r_flag  <= w_turn.neg;
                                r_phase <= PH_TEST_B;
                                r_state <= ST_RD_A;
                            end
                            PH_TEST_B: begin
                                if (r_flag && w_turn.neg) begin
                                    r_state <= ST_ITEM_END;
                                end else if (r_cnt > CNT_W'(2)) begin
                                    r_phase <= PH_POP_F;
                                    r_state <= ST_RD_A;
                                end else begin
                                    r_state <= ST_PUSH_F;
                                end
                            end
                            PH_POP_F: begin
                                if (!w_turn.neg) begin
                                    r_fp    <= slot_of(r_fp, CNT_W'(1));
                                    r_cnt   <= r_cnt - 1'b1;
                                    r_state <= (r_cnt > CNT_W'(3)) ? ST_RD_A : ST_PUSH_F;
                                end else begin
                                    r_state <= ST_PUSH_F;
                                end
                            end
                            default: begin
                                if (!w_turn.neg) begin
                                    r_cnt   <= r_cnt - 1'b1;
                                    r_state <= (r_cnt > CNT_W'(3)) ? ST_RD_A : ST_PUSH_B;
                                end else begin
                                    r_state <= ST_PUSH_B;
                                end
                            end
                        endcase
                    end
                end
                ST_PUSH_F: begin
                    r_phase <= PH_POP_B;
                    if (w_full) begin
                        r_ovf   <= 1'b1;
                        r_state <= (r_cnt > CNT_W'(2)) ? ST_RD_A : ST_PUSH_B;
                    end else begin
                        r_fp    <= w_fp_dec;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= (r_cnt >= CNT_W'(2)) ? ST_RD_A : ST_PUSH_B;
                    end
                end
                ST_PUSH_B: begin
                    if (w_full) r_ovf <= 1'b1;
                    else r_cnt <= r_cnt + 1'b1;
                    r_state <= ST_ITEM_END;
                end
                ST_ITEM_END: begin
                    r_state <= r_last ? ST_FINISH : ST_IDLE;
                end
                ST_FINISH: begin
                    if (w_err != spch_pkg::STAT_OK) begin
                        if (w_out_free) begin
                            r_out_last   <= 1'b1;
                            r_out_pt     <= '0;
                            r_out_len    <= '0;
                            r_out_status <= w_err;
                            r_fp         <= '0;
                            r_cnt        <= '0;
                            r_ps         <= '0;
                            r_ovf        <= 1'b0;
                            r_few        <= 1'b0;
                            r_state      <= ST_IDLE;
                        end
                    end else begin
                        r_len   <= w_len;
                        r_k     <= '0;
                        r_state <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD: r_state <= ST_EMIT_LD;
                ST_EMIT_LD: begin
                    if (w_out_free) begin
                        r_out_pt     <= r_rd_data;
                        r_out_len    <= spch_pkg::LEN_W'(r_len);
                        r_out_status <= spch_pkg::STAT_OK;
                        r_out_last   <= (r_k == r_len - 1'b1);
                        if (r_k == r_len - 1'b1) begin
                            r_fp    <= '0;
                            r_cnt   <= '0;
                            r_ps    <= '0;
                            r_ovf   <= 1'b0;
                            r_few   <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_len, r_out_pt.y, r_out_pt.x};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(spch_pkg::STORE_DEPTH))
        else $error("store count beyond depth");

    a_turn_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_turn.done |-> (r_state == ST_TURN || r_state == ST_SEED_TURN))
        else $error("turn result with no waiter");

    a_pair_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_A) |-> (r_cnt >= CNT_W'(2)))
        else $error("pair read with fewer than two entries");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != spch_pkg::STAT_OK) |->
        (r_out_last && r_out_len == '0))
        else $error("error beat not final or nonzero length");

    a_seed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED_WR && r_k == CNT_W'(3)) |=> (r_cnt == CNT_W'(4)))
        else $error("seeding left wrong count");

endmodule
